// File: sv/obd_resp_pkg.sv
package obd_resp_pkg;

   localparam int DATA_BYTES = 8;

   localparam logic       OP_FRAME  = 1'b0;
   localparam logic       OP_UPDATE = 1'b1;
   localparam logic [10:0] QUERY_ID = 11'h7DF;

   localparam logic [7:0] MODE_LIVE  = 8'h01;
   localparam logic [7:0] MODE_DTC   = 8'h03;
   localparam logic [7:0] MODE_CLEAR = 8'h04;
   localparam logic [7:0] MODE_PEND  = 8'h07;
   localparam logic [7:0] MODE_INFO  = 8'h09;

   localparam logic [7:0] PID_SUPP_00 = 8'h00;
   localparam logic [7:0] PID_COOLANT = 8'h05;
   localparam logic [7:0] PID_RPM     = 8'h0C;
   localparam logic [7:0] PID_SPEED   = 8'h0D;
   localparam logic [7:0] PID_IAT     = 8'h0F;
   localparam logic [7:0] PID_MAF     = 8'h10;
   localparam logic [7:0] PID_STD     = 8'h1C;
   localparam logic [7:0] PID_SUPP_20 = 8'h20;
   localparam logic [7:0] PID_FUEL    = 8'h2F;

   localparam logic [7:0] INFO_SUPP = 8'h00;
   localparam logic [7:0] INFO_VIN  = 8'h02;
   localparam logic [7:0] INFO_CAL  = 8'h04;

   localparam logic [2:0] SEL_SPEED   = 3'd0;
   localparam logic [2:0] SEL_RPM     = 3'd1;
   localparam logic [2:0] SEL_COOLANT = 3'd2;
   localparam logic [2:0] SEL_FUEL    = 3'd3;
   localparam logic [2:0] SEL_MIL     = 3'd4;

   localparam logic CSR_IAT = 1'b0;
   localparam logic CSR_MAF = 1'b1;

   localparam logic signed [8:0] IAT_RESET     = 9'sd90;
   localparam logic [15:0]       MAF_RESET     = 16'd900;
   localparam logic [13:0]       RPM_RESET     = 14'd1000;
   localparam logic signed [8:0] COOLANT_RESET = 9'sd95;
   localparam logic [6:0]        FUEL_RESET    = 7'd100;

   // byte 0 in the lowest bits
   localparam logic [63:0] PIDS_00_FRAME = 64'h00_01_00_1F_88_00_41_06;
   localparam logic [63:0] PIDS_20_FRAME = 64'h00_00_00_02_80_20_41_06;
   localparam logic [63:0] STD_FRAME     = 64'h00_00_00_00_0A_1C_41_04;
   localparam logic [63:0] INFO_00_FRAME = 64'h00_00_00_28_28_00_49_06;

   localparam logic [135:0] VIN_ROM = "SCBZK25EXYC813876";
   localparam logic [135:0] CAL_ROM = "FW00116MHZ1111111";

   localparam logic [9:0]  TEMP_OFFSET = 10'd40;
   localparam logic [12:0] FUEL_RECIP  = 13'd5243;

   typedef struct packed {
      logic              operation;
      logic [10:0]       frame_id;
      logic [7:0]        service_mode;
      logic [7:0]        pid_code;
      logic [2:0]        value_select;
      logic signed [16:0] new_value;
   } obd_item_type;

   typedef struct packed {
      logic signed [8:0] intake_air_temp;
      logic [15:0]       air_flow_rate;
      logic [7:0]        vehicle_speed;
      logic [13:0]       engine_rpm;
      logic signed [8:0] coolant_temp;
      logic [6:0]        fuel_percent;
      logic              mil_on;
   } obd_vehicle_type;

   typedef struct packed {
      logic [DATA_BYTES-1:0][7:0] data;
      logic                       last;
   } obd_frame_type;

   function automatic logic [7:0] rom_char(input logic [135:0] rom, input int k);
      rom_char = rom[8*(16-k) +: 8];
   endfunction

endpackage

// File: sv/obd_vehicle_state.sv
module obd_vehicle_state
   import obd_resp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata,
   input  logic            commit,
   input  obd_item_type    item,
   output obd_vehicle_type vehicle
);

   logic signed [8:0] iat_ff, iat_in;
   logic [15:0]       maf_ff, maf_in;
   logic [7:0]        speed_ff, speed_in;
   logic [13:0]       rpm_ff, rpm_in;
   logic signed [8:0] coolant_ff, coolant_in;
   logic [6:0]        fuel_ff, fuel_in;
   logic              mil_ff, mil_in;
   logic signed [16:0] v;
   logic              is_update;
   logic              is_clear;

   assign v         = item.new_value;
   assign is_update = commit && (item.operation == OP_UPDATE);
   assign is_clear  = commit && (item.operation == OP_FRAME) && (item.frame_id == QUERY_ID)
                      && (item.service_mode == MODE_CLEAR);

   always_comb begin
      iat_in     = iat_ff;
      maf_in     = maf_ff;
      speed_in   = speed_ff;
      rpm_in     = rpm_ff;
      coolant_in = coolant_ff;
      fuel_in    = fuel_ff;
      mil_in     = mil_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IAT: iat_in = csr_wdata[8:0];
            CSR_MAF: maf_in = csr_wdata;
            default: ;
         endcase
      end
      if (is_clear) begin
         mil_in = 1'b0;
      end
      if (is_update) begin
         case (item.value_select)
            SEL_SPEED: begin
               if (v < 17'sd0)        speed_in = 8'd0;
               else if (v > 17'sd255) speed_in = 8'd255;
               else                   speed_in = v[7:0];
            end
            SEL_RPM: begin
               if (v < 17'sd0)          rpm_in = 14'd0;
               else if (v > 17'sd16383) rpm_in = 14'd16383;
               else                     rpm_in = v[13:0];
            end
            SEL_COOLANT: begin
               if (v < -17'sd40)      coolant_in = -9'sd40;
               else if (v > 17'sd215) coolant_in = 9'sd215;
               else                   coolant_in = v[8:0];
            end
            SEL_FUEL: begin
               if (v < 17'sd0)        fuel_in = 7'd0;
               else if (v > 17'sd100) fuel_in = 7'd100;
               else                   fuel_in = v[6:0];
            end
            SEL_MIL: mil_in = (v != 17'sd0);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iat_ff     <= IAT_RESET;
         maf_ff     <= MAF_RESET;
         speed_ff   <= 8'd0;
         rpm_ff     <= RPM_RESET;
         coolant_ff <= COOLANT_RESET;
         fuel_ff    <= FUEL_RESET;
         mil_ff     <= 1'b0;
      end else begin
         iat_ff     <= iat_in;
         maf_ff     <= maf_in;
         speed_ff   <= speed_in;
         rpm_ff     <= rpm_in;
         coolant_ff <= coolant_in;
         fuel_ff    <= fuel_in;
         mil_ff     <= mil_in;
      end
   end

   assign vehicle.intake_air_temp = iat_ff;
   assign vehicle.air_flow_rate   = maf_ff;
   assign vehicle.vehicle_speed   = speed_ff;
   assign vehicle.engine_rpm      = rpm_ff;
   assign vehicle.coolant_temp    = coolant_ff;
   assign vehicle.fuel_percent    = fuel_ff;
   assign vehicle.mil_on          = mil_ff;

endmodule

// File: sv/obd_frame_gen.sv
module obd_frame_gen
   import obd_resp_pkg::*;
(
   input  obd_item_type    item,
   input  obd_vehicle_type vehicle,
   input  logic [1:0]      frame_idx,
   output logic [1:0]      frame_count,
   output obd_frame_type   frame
);

   logic signed [9:0] coolant_ofs;
   logic signed [9:0] iat_ofs;
   logic [7:0]        coolant_byte;
   logic [7:0]        iat_byte;
   logic [14:0]       fuel_x255;
   logic [27:0]       fuel_prod;
   logic [15:0]       rpm_x4;
   logic [135:0]      rom;

   assign coolant_ofs = {vehicle.coolant_temp[8], vehicle.coolant_temp} + $signed(TEMP_OFFSET);
   assign iat_ofs     = {vehicle.intake_air_temp[8], vehicle.intake_air_temp}
                        + $signed(TEMP_OFFSET);

   always_comb begin
      if (coolant_ofs < 10'sd0)        coolant_byte = 8'd0;
      else if (coolant_ofs > 10'sd255) coolant_byte = 8'd255;
      else                             coolant_byte = coolant_ofs[7:0];
      if (iat_ofs < 10'sd0)            iat_byte = 8'd0;
      else if (iat_ofs > 10'sd255)     iat_byte = 8'd255;
      else                             iat_byte = iat_ofs[7:0];
   end

   // pct * 255 / 100 via reciprocal of 100 scaled by 2^19
   assign fuel_x255 = {vehicle.fuel_percent, 8'd0} - {8'd0, vehicle.fuel_percent};
   assign fuel_prod = fuel_x255 * FUEL_RECIP;
   assign rpm_x4    = {vehicle.engine_rpm, 2'b00};
   assign rom       = (item.pid_code == INFO_VIN) ? VIN_ROM : CAL_ROM;

   always_comb begin
      frame_count = 2'd0;
      frame       = '0;
      if (item.operation == OP_FRAME && item.frame_id == QUERY_ID) begin
         case (item.service_mode)
            MODE_LIVE: begin
               frame.last    = 1'b1;
               frame.data[0] = 8'd3;
               frame.data[1] = 8'h41;
               frame.data[2] = item.pid_code;
               frame_count   = 2'd1;
               case (item.pid_code)
                  PID_SUPP_00: frame.data = PIDS_00_FRAME;
                  PID_SUPP_20: frame.data = PIDS_20_FRAME;
                  PID_STD:     frame.data = STD_FRAME;
                  PID_COOLANT: frame.data[3] = coolant_byte;
                  PID_IAT:     frame.data[3] = iat_byte;
                  PID_SPEED:   frame.data[3] = vehicle.vehicle_speed;
                  PID_FUEL:    frame.data[3] = fuel_prod[26:19];
                  PID_RPM: begin
                     frame.data[0] = 8'd4;
                     frame.data[3] = rpm_x4[15:8];
                     frame.data[4] = rpm_x4[7:0];
                  end
                  PID_MAF: begin
                     frame.data[0] = 8'd4;
                     frame.data[3] = vehicle.air_flow_rate[15:8];
                     frame.data[4] = vehicle.air_flow_rate[7:0];
                  end
                  default: begin
                     frame_count = 2'd0;
                     frame       = '0;
                  end
               endcase
            end
            MODE_DTC, MODE_PEND: begin
               if (vehicle.mil_on) begin
                  frame_count   = 2'd1;
                  frame.last    = 1'b1;
                  frame.data[0] = 8'd6;
                  frame.data[1] = 8'h40 + item.service_mode;
                  frame.data[2] = 8'h02;
                  frame.data[3] = 8'h02;
                  frame.data[4] = 8'h61;
                  frame.data[5] = 8'h07;
               end
            end
            MODE_INFO: begin
               if (item.pid_code == INFO_SUPP) begin
                  frame_count = 2'd1;
                  frame.last  = 1'b1;
                  frame.data  = INFO_00_FRAME;
               end else if (item.pid_code == INFO_VIN || item.pid_code == INFO_CAL) begin
                  frame_count = 2'd3;
                  case (frame_idx)
                     2'd0: begin
                        frame.data[0] = 8'h10;
                        frame.data[1] = 8'd20;
                        frame.data[2] = 8'h49;
                        frame.data[3] = item.pid_code;
                        frame.data[4] = 8'd1;
                        for (int k = 0; k < 3; k++) begin
                           frame.data[5+k] = rom_char(rom, k);
                        end
                     end
                     2'd1: begin
                        frame.data[0] = 8'h21;
                        for (int k = 0; k < 7; k++) begin
                           frame.data[1+k] = rom_char(rom, 3 + k);
                        end
                     end
                     default: begin
                        frame.last    = 1'b1;
                        frame.data[0] = 8'h22;
                        for (int k = 0; k < 7; k++) begin
                           frame.data[1+k] = rom_char(rom, 10 + k);
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// File: sv/obd2_ecu_responder.sv
// OBD-II engine ECU responder. Each req beat is either a received CAN frame
// (tuser low) or an update of a stored vehicle value (tuser high). Frames
// addressed to the functional id 0x7DF are answered with 8-byte reply beats
// on rsp, tlast marking the last reply of a request. Items are held in one
// input register and replies built into one output register, so one item is
// taken per cycle unless rsp stalls a reply; a VIN or calibration-ID request
// holds the input register for its three reply frames. Updates, mode 4 and
// unanswered frames need no output slot. The csr port writes intake air temp
// (index 0, 9-bit signed) and MAF (index 1) and should only be used when idle.
module obd2_ecu_responder
   import obd_resp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // frame_id, service_mode, pid_code, value_select, new_value, zero pad
   input  logic [47:0] req_tdata,
   // operation
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_byte0 .. frame_byte7
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   obd_item_type    item_ff, item_in;
   logic            item_valid_ff, item_valid_in;
   logic [1:0]      idx_ff, idx_in;
   obd_frame_type   out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   obd_vehicle_type vehicle;
   obd_frame_type   frame;
   logic [1:0]      frame_count;
   logic            out_free;
   logic            advance;
   logic            done;
   logic            accept;

   obd_vehicle_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .commit    (done),
      .item      (item_ff),
      .vehicle   (vehicle)
   );

   obd_frame_gen u_frame (
      .item        (item_ff),
      .vehicle     (vehicle),
      .frame_idx   (idx_ff),
      .frame_count (frame_count),
      .frame       (frame)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && (frame_count == 2'd0 || out_free);
   assign done       = advance && (frame_count == 2'd0 || idx_ff == frame_count - 2'd1);
   assign req_tready = !item_valid_ff || done;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      idx_in        = idx_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      if (done) begin
         item_valid_in = 1'b0;
         idx_in        = 2'd0;
      end else if (advance) begin
         idx_in = idx_ff + 2'd1;
      end
      if (accept) begin
         item_valid_in         = 1'b1;
         item_in.operation     = req_tuser;
         item_in.frame_id      = req_tdata[10:0];
         item_in.service_mode  = req_tdata[18:11];
         item_in.pid_code      = req_tdata[26:19];
         item_in.value_select  = req_tdata[29:27];
         item_in.new_value     = req_tdata[46:30];
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && frame_count != 2'd0) begin
         out_valid_in = 1'b1;
         out_in       = frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tlast  = out_ff.last;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd3)
      else $error("reply frame index out of range");

   a_accept_only_when_done: assert property (@(posedge clock) disable iff (reset)
      accept && item_valid_ff |-> done)
      else $error("item overwritten before completion");

   a_more_frames_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> item_valid_ff)
      else $error("non-final reply with no request pending");

   a_clear_mil: assert property (@(posedge clock) disable iff (reset)
      done && !csr_we && item_ff.operation == OP_FRAME && item_ff.frame_id == QUERY_ID
      && item_ff.service_mode == MODE_CLEAR |=> !vehicle.mil_on)
      else $error("mil still on after clear request");

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import obd_resp_pkg::*;

   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 66;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCH_LIMIT  = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // frame_id, service_mode, pid_code, value_select, new_value, zero pad
   logic [47:0] req_tdata = '0;
   // operation
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // frame_byte0 .. frame_byte7
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   bit idle_on  = 1'b1;
   bit hold_off = 1'b0;
   int idle_cycles = 0;

   logic [7:0] live_pids [9] = '{PID_SUPP_00, PID_COOLANT, PID_RPM, PID_SPEED, PID_IAT,
                                 PID_MAF, PID_STD, PID_SUPP_20, PID_FUEL};

   // expected ecu replies, worked out from the vehicle state and csr values
   class reply_book;
      obd_frame_type     reply_q[$];
      logic signed [8:0] iat;
      logic [15:0]       maf;
      logic [7:0]        speed;
      logic [13:0]       rpm;
      logic signed [8:0] coolant;
      logic [6:0]        fuel;
      logic              mil;
      string             vin;
      string             cal;
      int                errors;
      int                n_frames;
      int                n_updates;
      int                n_replies;
      int                n_settings;

      function new();
         iat        = 9'sd90;
         maf        = 16'd900;
         speed      = 8'd0;
         rpm        = 14'd1000;
         coolant    = 9'sd95;
         fuel       = 7'd100;
         mil        = 1'b0;
         vin        = "SCBZK25EXYC813876";
         cal        = "FW00116MHZ1111111";
         errors     = 0;
         n_frames   = 0;
         n_updates  = 0;
         n_replies  = 0;
         n_settings = 1;
      endfunction

      function int clamp(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void add(input logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7, input logic last);
         obd_frame_type f;
         f.data[0] = b0;
         f.data[1] = b1;
         f.data[2] = b2;
         f.data[3] = b3;
         f.data[4] = b4;
         f.data[5] = b5;
         f.data[6] = b6;
         f.data[7] = b7;
         f.last    = last;
         reply_q.push_back(f);
      endfunction

      function void set_regs(logic [15:0] iat_word, logic [15:0] maf_word);
         iat = iat_word[8:0];
         maf = maf_word;
         n_settings++;
      endfunction

      function void live_reply(logic [7:0] pid);
         int t;
         int r;
         case (pid)
            PID_SUPP_00: add(8'h06, 8'h41, 8'h00, 8'h88, 8'h1F, 8'h00, 8'h01, 8'h00, 1'b1);
            PID_SUPP_20: add(8'h06, 8'h41, 8'h20, 8'h80, 8'h02, 8'h00, 8'h00, 8'h00, 1'b1);
            PID_STD:     add(8'h04, 8'h41, 8'h1C, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
            PID_COOLANT: begin
               t = coolant;
               r = clamp(t + 40, 0, 255);
               add(8'h03, 8'h41, pid, r[7:0], 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
            end
            PID_IAT: begin
               t = iat;
               r = clamp(t + 40, 0, 255);
               add(8'h03, 8'h41, pid, r[7:0], 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
            end
            PID_SPEED: add(8'h03, 8'h41, pid, speed, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
            PID_FUEL: begin
               t = fuel;
               r = t * 255 / 100;
               add(8'h03, 8'h41, pid, r[7:0], 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
            end
            PID_RPM: begin
               t = rpm;
               r = t * 4;
               add(8'h04, 8'h41, pid, r[15:8], r[7:0], 8'h00, 8'h00, 8'h00, 1'b1);
            end
            PID_MAF: add(8'h04, 8'h41, pid, maf[15:8], maf[7:0], 8'h00, 8'h00, 8'h00, 1'b1);
            default: ;
         endcase
      endfunction

      function void info_reply(logic [7:0] pid);
         string s;
         if (pid == INFO_SUPP) begin
            add(8'h06, 8'h49, 8'h00, 8'h28, 8'h28, 8'h00, 8'h00, 8'h00, 1'b1);
            return;
         end
         if (pid == INFO_VIN)
            s = vin;
         else if (pid == INFO_CAL)
            s = cal;
         else
            return;
         // iso-tp first frame then two consecutive frames
         add(8'h10, 8'd20, 8'h49, pid, 8'h01, s[0], s[1], s[2], 1'b0);
         add(8'h21, s[3], s[4], s[5], s[6], s[7], s[8], s[9], 1'b0);
         add(8'h22, s[10], s[11], s[12], s[13], s[14], s[15], s[16], 1'b1);
      endfunction

      function void take_request(obd_item_type it);
         int v;
         logic [7:0] md;
         if (it.operation == OP_UPDATE) begin
            n_updates++;
            v = it.new_value;
            case (it.value_select)
               SEL_SPEED:   speed   = 8'(clamp(v, 0, 255));
               SEL_RPM:     rpm     = 14'(clamp(v, 0, 16383));
               SEL_COOLANT: coolant = 9'(clamp(v, -40, 215));
               SEL_FUEL:    fuel    = 7'(clamp(v, 0, 100));
               SEL_MIL:     mil     = (v != 0);
               default: ;
            endcase
            return;
         end
         n_frames++;
         if (it.frame_id != QUERY_ID)
            return;
         md = it.service_mode;
         case (md)
            MODE_LIVE: live_reply(it.pid_code);
            MODE_DTC, MODE_PEND: begin
               if (mil)
                  add(8'h06, 8'h40 + md, 8'h02, 8'h02, 8'h61, 8'h07, 8'h00, 8'h00, 1'b1);
            end
            MODE_CLEAR: mil = 1'b0;
            MODE_INFO: info_reply(it.pid_code);
            default: ;
         endcase
      endfunction

      function void check_reply(logic [63:0] data, logic last);
         obd_frame_type want;
         int k;
         n_replies++;
         if (reply_q.size() == 0) begin
            flag($sformatf("reply beat %h last %b with nothing expected", data, last));
            return;
         end
         want = reply_q.pop_front();
         for (k = 0; k < 8; k++) begin
            if (data[8*k +: 8] !== want.data[k])
               flag($sformatf("reply byte %0d expected %h got %h", k, want.data[k],
                              data[8*k +: 8]));
         end
         if (last !== want.last)
            flag($sformatf("reply tlast expected %b got %b", want.last, last));
      endfunction
   endclass

   reply_book book = new();

   obd2_ecu_responder dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic obd_item_type ask(logic [10:0] id, logic [7:0] mode, logic [7:0] pid);
      obd_item_type it;
      it = '0;
      it.operation    = OP_FRAME;
      it.frame_id     = id;
      it.service_mode = mode;
      it.pid_code     = pid;
      return it;
   endfunction

   function automatic obd_item_type set_value(logic [2:0] sel, logic [16:0] val);
      obd_item_type it;
      it = '0;
      it.operation    = OP_UPDATE;
      it.value_select = sel;
      it.new_value    = val;
      return it;
   endfunction

   function automatic obd_item_type random_item();
      obd_item_type it;
      int r;
      int v;
      it.operation = ($urandom_range(0, 3) == 0) ? OP_UPDATE : OP_FRAME;
      it.frame_id  = ($urandom_range(0, 99) < 92) ? QUERY_ID : 11'($urandom);
      r = $urandom_range(0, 99);
      if (r < 50)
         it.service_mode = MODE_LIVE;
      else if (r < 60)
         it.service_mode = MODE_DTC;
      else if (r < 70)
         it.service_mode = MODE_PEND;
      else if (r < 74)
         it.service_mode = MODE_CLEAR;
      else if (r < 90)
         it.service_mode = MODE_INFO;
      else
         it.service_mode = 8'($urandom);
      if ($urandom_range(0, 9) == 0)
         it.pid_code = 8'($urandom);
      else if (it.service_mode == MODE_INFO)
         it.pid_code = 8'(2 * $urandom_range(0, 2));
      else
         it.pid_code = live_pids[$urandom_range(0, 8)];
      it.value_select = ($urandom_range(0, 99) < 94) ? 3'($urandom_range(0, 4))
                                                     : 3'($urandom_range(5, 7));
      case (it.value_select)
         SEL_SPEED:   v = $urandom_range(0, 255);
         SEL_RPM:     v = $urandom_range(0, 16383);
         SEL_COOLANT: v = int'($urandom_range(0, 255)) - 40;
         SEL_FUEL:    v = $urandom_range(0, 100);
         SEL_MIL:     v = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : 0;
         default:     v = $urandom;
      endcase
      // whole field range, saturation included
      if ($urandom_range(0, 3) == 0)
         v = $urandom;
      it.new_value = v[16:0];
      return it;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(obd_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.operation;
      req_tdata  <= {1'b0, it.new_value, it.value_select, it.pid_code, it.service_mode,
                     it.frame_id};
      do @(posedge clock); while (!req_tready);
      book.take_request(it);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] iat_word, logic [15:0] maf_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_IAT;
      csr_wdata <= iat_word;
      @(posedge clock);
      csr_index <= CSR_MAF;
      csr_wdata <= maf_word;
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_regs(iat_word, maf_word);
   endtask

   // output side: random stalls, plus one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_reply(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCH_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   initial begin
      obd_item_type plan[$];
      obd_item_type it;
      logic [15:0]  iat_word;
      logic [15:0]  maf_word;
      int           phase;
      int           sent;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values first, then the special cases
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_SUPP_00));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_SUPP_20));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_STD));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_COOLANT));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_IAT));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_RPM));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_SPEED));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_MAF));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, PID_FUEL));
      plan.push_back(ask(QUERY_ID, MODE_LIVE, 8'hFF));
      plan.push_back(ask(QUERY_ID, MODE_INFO, INFO_SUPP));
      plan.push_back(ask(QUERY_ID, MODE_INFO, INFO_VIN));
      plan.push_back(ask(QUERY_ID, MODE_INFO, INFO_CAL));
      plan.push_back(ask(QUERY_ID, MODE_INFO, 8'h01));
      plan.push_back(ask(QUERY_ID, MODE_DTC, 8'h00));
      plan.push_back(set_value(SEL_MIL, 17'h1_0000));
      plan.push_back(ask(QUERY_ID, MODE_DTC, 8'h00));
      plan.push_back(ask(QUERY_ID, MODE_PEND, 8'h00));
      plan.push_back(ask(QUERY_ID, MODE_CLEAR, 8'h00));
      plan.push_back(ask(QUERY_ID, MODE_PEND, 8'h00));
      plan.push_back(ask(11'h7E0, MODE_LIVE, PID_SUPP_00));
      plan.push_back(ask(QUERY_ID, 8'hFF, PID_SUPP_00));
      plan.push_back(set_value(SEL_SPEED, 17'h0_FFFF));
      plan.push_back(set_value(SEL_RPM, 17'h1_0000));
      plan.push_back(set_value(SEL_COOLANT, 17'h1_0000));
      plan.push_back(set_value(SEL_FUEL, 17'h0_FFFF));
      plan.push_back(set_value(3'd7, 17'h0_0005));
      foreach (plan[i])
         send_item(plan[i]);

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin iat_word = 16'hFFD8; maf_word = 16'h0000; end
            1: begin iat_word = 16'h00D7; maf_word = 16'hFFFF; end
            2: begin iat_word = 16'hFF00; maf_word = 16'h00FF; end
            3: begin iat_word = 16'h00FF; maf_word = 16'hFF00; end
            default: begin iat_word = 16'($urandom); maf_word = 16'($urandom); end
         endcase
         write_regs(iat_word, maf_word);
         idle_on = (phase != 4);
         if (phase == 2)
            hold_off = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            it = random_item();
            send_item(it);
            sent++;
         end
      end
      idle_on = 1'b1;
      settle();

      if (book.reply_q.size() != 0)
         book.flag($sformatf("%0d reply beats never arrived", book.reply_q.size()));
      $display("covered %0d can frames and %0d value updates, %0d reply beats checked",
               book.n_frames, book.n_updates, book.n_replies);
      $display("across %0d csr settings, with random stalls and one long output hold-off",
               book.n_settings);
      if (book.errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// File: obd2_ecu_responder.f
sv/obd_resp_pkg.sv
sv/obd_vehicle_state.sv
sv/obd_frame_gen.sv
sv/obd2_ecu_responder.sv
tb/testbench.sv
